// ----- rtl/pcrb_pkg.sv -----
// shared constants, command and entry types for the pulse capture ring buffer
`default_nettype none

package pcrb_pkg;

  // ring depth, a power of two so that ring arithmetic wraps on the address width
  localparam int DEPTH   = 2048;
  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int FUNC_W  = 3;
  localparam int DUR_W   = 32;
  localparam int POS_W   = 32;

  // command queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // func codes as seen on the input channel
  localparam logic [FUNC_W-1:0] FUNC_APPEND = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_MERGE  = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_READ   = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_ROTATE = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 3'd4;

  // classified operation carried to the back end
  typedef enum logic [2:0] {
    CMD_APPEND,
    CMD_MERGE,
    CMD_READ,
    CMD_ROTATE,
    CMD_CLEAR,
    CMD_NOP
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t           op;
    logic              level;
    logic [DUR_W-1:0]  dur;
    logic [ADDR_W-1:0] offset;
  } cmd_t;

  typedef struct packed {
    logic             level;
    logic [DUR_W-1:0] dur;
  } entry_t;

endpackage

`default_nettype wire

// ----- rtl/pcrb_front.sv -----
// front end: takes input items, classifies the operation and queues a command
`default_nettype none

module pcrb_front (
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic [pcrb_pkg::FUNC_W-1:0]  in_func,
  input  wire logic                         in_pulse_level,
  input  wire logic [pcrb_pkg::DUR_W-1:0]   in_pulse_duration,
  input  wire logic [pcrb_pkg::POS_W-1:0]   in_position,
  input  wire logic                         q_full,
  input  wire logic                         clearing,
  output logic                              q_push,
  output pcrb_pkg::cmd_t                    q_cmd
);

  pcrb_pkg::cmd_op_t op;

  // map func codes onto operations, unused codes become a no-op
  always_comb begin
    case (in_func)
      pcrb_pkg::FUNC_APPEND: op = pcrb_pkg::CMD_APPEND;
      pcrb_pkg::FUNC_MERGE:  op = pcrb_pkg::CMD_MERGE;
      pcrb_pkg::FUNC_READ:   op = pcrb_pkg::CMD_READ;
      pcrb_pkg::FUNC_ROTATE: op = pcrb_pkg::CMD_ROTATE;
      pcrb_pkg::FUNC_CLEAR:  op = pcrb_pkg::CMD_CLEAR;
      default:               op = pcrb_pkg::CMD_NOP;
    endcase
  end

  // no items while the queue is full or the store is being swept
  assign in_stall = q_full | clearing;
  assign q_push   = in_valid & ~in_stall;

  // position modulo depth is its low address bits
  always_comb begin
    q_cmd.op     = op;
    q_cmd.level  = in_pulse_level;
    q_cmd.dur    = in_pulse_duration;
    q_cmd.offset = in_position[pcrb_pkg::ADDR_W-1:0];
  end

endmodule

`default_nettype wire

// ----- rtl/pcrb_fifo.sv -----
// short command queue between front and back end
`default_nettype none

module pcrb_fifo (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push,
  input  wire pcrb_pkg::cmd_t  push_cmd,
  output logic                 full,
  input  wire logic            pop,
  output logic                 empty,
  output pcrb_pkg::cmd_t       pop_cmd
);

  pcrb_pkg::cmd_t                 slot_r [pcrb_pkg::QUEUE_DEPTH];
  logic [pcrb_pkg::QPTR_W-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [pcrb_pkg::QPTR_W-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [pcrb_pkg::QCNT_W-1:0]    count_r, count_nxt;

  assign full    = (count_r == pcrb_pkg::QCNT_W'(pcrb_pkg::QUEUE_DEPTH));
  assign empty   = (count_r == '0);
  assign pop_cmd = slot_r[rd_ptr_r];

  // pointer and fill count update with wrap
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == pcrb_pkg::QPTR_W'(pcrb_pkg::QUEUE_DEPTH - 1)) ?
                   '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == pcrb_pkg::QPTR_W'(pcrb_pkg::QUEUE_DEPTH - 1)) ?
                   '0 : rd_ptr_r + 1'b1;
    end
    case ({push, pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // queue slots carry payload only
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/pcrb_back.sv -----
// back end: pulse store, head index, clearing sweep and result register
`default_nettype none

module pcrb_back (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        q_empty,
  input  wire pcrb_pkg::cmd_t              q_cmd,
  output logic                             q_pop,
  output logic                             clearing,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic                             out_read_level,
  output logic [pcrb_pkg::DUR_W-1:0]       out_read_duration,
  output logic                             out_merged,
  output logic                             out_saturated
);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RDATA,
    ST_MERGE
  } state_t;

  localparam int AW = pcrb_pkg::ADDR_W;
  localparam int DW = pcrb_pkg::DUR_W;

  state_t               state_r, state_nxt;
  logic [AW-1:0]        head_r, head_nxt;
  logic [AW-1:0]        clr_r, clr_nxt;
  pcrb_pkg::cmd_t       cmd_r, cmd_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic                 read_level_r;
  logic [DW-1:0]        read_duration_r;
  logic                 merged_r;
  logic                 saturated_r;

  // memory side
  pcrb_pkg::entry_t     mem [pcrb_pkg::DEPTH];
  pcrb_pkg::entry_t     rd_data_r;
  pcrb_pkg::entry_t     wr_data;
  logic                 wr_en, rd_en;
  logic [AW-1:0]        wr_addr, rd_addr;

  // result being loaded this cycle
  logic                 res_load;
  logic                 res_level;
  logic [DW-1:0]        res_dur;
  logic                 res_merged;
  logic                 res_sat;

  logic                 out_free;
  logic [DW:0]          sum;
  logic [AW-1:0]        prev_addr;

  assign out_free  = ~out_valid_r | ~out_stall;
  assign sum       = {1'b0, rd_data_r.dur} + {1'b0, cmd_r.dur};
  assign prev_addr = head_r - AW'(1);
  assign clearing  = (state_r == ST_CLEAR);

  // sequencer
  always_comb begin
    state_nxt  = state_r;
    head_nxt   = head_r;
    clr_nxt    = clr_r;
    cmd_nxt    = cmd_r;
    q_pop      = 1'b0;
    wr_en      = 1'b0;
    wr_addr    = head_r;
    wr_data    = '0;
    rd_en      = 1'b0;
    rd_addr    = head_r + q_cmd.offset;
    res_load   = 1'b0;
    res_level  = 1'b0;
    res_dur    = '0;
    res_merged = 1'b0;
    res_sat    = 1'b0;
    case (state_r)
      ST_CLEAR: begin
        // zero one entry a cycle
        wr_en   = 1'b1;
        wr_addr = clr_r;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == AW'(pcrb_pkg::DEPTH - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (!q_empty && out_free) begin
          q_pop   = 1'b1;
          cmd_nxt = q_cmd;
          case (q_cmd.op)
            pcrb_pkg::CMD_APPEND: begin
              wr_en    = 1'b1;
              wr_data  = '{level: q_cmd.level, dur: q_cmd.dur};
              head_nxt = head_r + 1'b1;
              res_load = 1'b1;
            end
            pcrb_pkg::CMD_MERGE: begin
              rd_en     = 1'b1;
              rd_addr   = prev_addr;
              state_nxt = ST_MERGE;
            end
            pcrb_pkg::CMD_READ: begin
              rd_en     = 1'b1;
              state_nxt = ST_RDATA;
            end
            pcrb_pkg::CMD_ROTATE: begin
              head_nxt = head_r + q_cmd.offset;
              res_load = 1'b1;
            end
            pcrb_pkg::CMD_CLEAR: begin
              head_nxt  = '0;
              clr_nxt   = '0;
              state_nxt = ST_CLEAR;
              res_load  = 1'b1;
            end
            default: begin
              res_load = 1'b1;
            end
          endcase
        end
      end
      ST_RDATA: begin
        if (out_free) begin
          res_load  = 1'b1;
          res_level = rd_data_r.level;
          res_dur   = rd_data_r.dur;
          state_nxt = ST_IDLE;
        end
      end
      ST_MERGE: begin
        if (out_free) begin
          res_load  = 1'b1;
          wr_en     = 1'b1;
          state_nxt = ST_IDLE;
          if (rd_data_r.level == cmd_r.level && rd_data_r.dur != '0) begin
            // extend the previous run, clip at full scale
            wr_addr       = prev_addr;
            wr_data.level = cmd_r.level;
            wr_data.dur   = sum[DW] ? '1 : sum[DW-1:0];
            res_merged    = 1'b1;
            res_sat       = sum[DW];
          end else begin
            wr_data  = '{level: cmd_r.level, dur: cmd_r.dur};
            head_nxt = head_r + 1'b1;
          end
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
        clr_nxt   = '0;
      end
    endcase
  end

  // result handshake
  always_comb begin
    if (res_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      head_r      <= '0;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cmd_r <= cmd_nxt;
    if (res_load) begin
      read_level_r    <= res_level;
      read_duration_r <= res_dur;
      merged_r        <= res_merged;
      saturated_r     <= res_sat;
    end
  end

  // pulse store, one write and one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign out_valid         = out_valid_r;
  assign out_read_level    = read_level_r;
  assign out_read_duration = read_duration_r;
  assign out_merged        = merged_r;
  assign out_saturated     = saturated_r;

  // checks
  a_no_pop_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLEAR) |-> !q_pop)
    else $error("command taken during clearing sweep");

  a_result_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    res_load |-> out_free)
    else $error("result loaded over a waiting result");

  a_clear_resets_head: assert property (@(posedge clk) disable iff (!rst_n)
    (q_pop && q_cmd.op == pcrb_pkg::CMD_CLEAR) |=> (head_r == '0 && state_r == ST_CLEAR))
    else $error("clear did not restart the sweep at head zero");

  a_merge_hits_prev: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MERGE && res_merged) |-> (wr_en && wr_addr == prev_addr))
    else $error("merge wrote somewhere other than the previous entry");

endmodule

`default_nettype wire

// ----- rtl/pulse_capture_ring_buffer.sv -----
// top level of the pulse capture ring buffer
`default_nettype none

// Ring store of 2048 captured pulses (level bit and 32-bit duration) with a
// head index, driven by one command per item: append, append-or-merge, read,
// rotate head and clear. Every item gives exactly one result. Append, rotate,
// clear and unused codes load their result when taken; read and merge pass
// through a second state, as the store's read port is registered; a merge
// writes the summed duration back to the previous entry or, if it cannot
// extend, appends. A two-entry command queue lets items be taken while a
// result waits on out_stall. After reset and after every clear the store is
// swept to zero, one entry a cycle; in_stall stays high during the sweep.

module pulse_capture_ring_buffer (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic [pcrb_pkg::FUNC_W-1:0]  in_func,
  input  wire logic                         in_pulse_level,
  input  wire logic [pcrb_pkg::DUR_W-1:0]   in_pulse_duration,
  input  wire logic [pcrb_pkg::POS_W-1:0]   in_position,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic                              out_read_level,
  output logic [pcrb_pkg::DUR_W-1:0]        out_read_duration,
  output logic                              out_merged,
  output logic                              out_saturated
);

  pcrb_pkg::cmd_t push_cmd;
  pcrb_pkg::cmd_t pop_cmd;
  logic           push, pop, full, empty, clearing;

  // front end
  pcrb_front u_front (
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_func           (in_func),
    .in_pulse_level    (in_pulse_level),
    .in_pulse_duration (in_pulse_duration),
    .in_position       (in_position),
    .q_full            (full),
    .clearing          (clearing),
    .q_push            (push),
    .q_cmd             (push_cmd)
  );

  // command queue
  pcrb_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (full),
    .pop      (pop),
    .empty    (empty),
    .pop_cmd  (pop_cmd)
  );

  // back end
  pcrb_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_empty           (empty),
    .q_cmd             (pop_cmd),
    .q_pop             (pop),
    .clearing          (clearing),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_read_level    (out_read_level),
    .out_read_duration (out_read_duration),
    .out_merged        (out_merged),
    .out_saturated     (out_saturated)
  );

endmodule

`default_nettype wire

// ----- dv/pulse_capture_ring_buffer_test.sv -----
// self-checking testbench for the pulse capture ring buffer
`timescale 1ns / 100ps

module pulse_capture_ring_buffer_test;

  // func codes the block leaves unused
  localparam logic [pcrb_pkg::FUNC_W-1:0] FUNC_RSVD_A = 3'd5;
  localparam logic [pcrb_pkg::FUNC_W-1:0] FUNC_RSVD_B = 3'd6;
  localparam logic [pcrb_pkg::FUNC_W-1:0] FUNC_RSVD_C = 3'd7;

  localparam int RANDOM_ITEMS = 1100;
  localparam int MAX_CLEARS   = 12;
  localparam int DRAIN_CYCLES = 64;
  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic                       level;
    logic [pcrb_pkg::DUR_W-1:0] dur;
    logic                       merged;
    logic                       saturated;
  } pulse_result_t;

  typedef struct packed {
    logic [pcrb_pkg::FUNC_W-1:0] func;
    logic                        level;
    logic [pcrb_pkg::DUR_W-1:0]  dur;
    logic [pcrb_pkg::POS_W-1:0]  pos;
    logic                        typed;
    pulse_result_t               want;
  } stim_row_t;

  logic                        clk;
  logic                        rst_n;
  logic                        in_valid;
  logic                        in_stall;
  logic [pcrb_pkg::FUNC_W-1:0] in_func;
  logic                        in_pulse_level;
  logic [pcrb_pkg::DUR_W-1:0]  in_pulse_duration;
  logic [pcrb_pkg::POS_W-1:0]  in_position;
  logic                        out_valid;
  logic                        out_stall;
  logic                        out_read_level;
  logic [pcrb_pkg::DUR_W-1:0]  out_read_duration;
  logic                        out_merged;
  logic                        out_saturated;

  // typed expectation travelling with the item on the input port
  logic              cur_typed;
  pulse_result_t     cur_want;

  int idle_pct;
  int stall_pct;
  int fail_count;

  // predictor state
  logic                        ring_level [pcrb_pkg::DEPTH];
  logic [pcrb_pkg::DUR_W-1:0]  ring_dur   [pcrb_pkg::DEPTH];
  logic [pcrb_pkg::ADDR_W-1:0] ring_head;

  pulse_result_t pending_results [$];
  stim_row_t     directed_rows [$];

  pulse_capture_ring_buffer dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_func           (in_func),
    .in_pulse_level    (in_pulse_level),
    .in_pulse_duration (in_pulse_duration),
    .in_position       (in_position),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_read_level    (out_read_level),
    .out_read_duration (out_read_duration),
    .out_merged        (out_merged),
    .out_saturated     (out_saturated)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // hard limit on run length
  initial begin
    #5_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // result back-pressure
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // apply one operation to the ring copy and return its result
  function automatic pulse_result_t predict_ring_result(
      input logic [pcrb_pkg::FUNC_W-1:0] f,
      input logic lv,
      input logic [pcrb_pkg::DUR_W-1:0] d,
      input logic [pcrb_pkg::POS_W-1:0] p);
    pulse_result_t               r;
    logic [pcrb_pkg::ADDR_W-1:0] addr;
    logic [pcrb_pkg::ADDR_W-1:0] prev_idx;
    logic [pcrb_pkg::DUR_W:0]    sum;
    bit                          do_append;
    r = '0;
    do_append = 1'b0;
    addr = ring_head + p[pcrb_pkg::ADDR_W-1:0];
    prev_idx = ring_head - 1'b1;
    sum = {1'b0, ring_dur[prev_idx]} + {1'b0, d};
    case (f)
      pcrb_pkg::FUNC_APPEND: do_append = 1'b1;
      pcrb_pkg::FUNC_MERGE: begin
        if (ring_level[prev_idx] == lv && ring_dur[prev_idx] != '0) begin
          r.merged = 1'b1;
          if (sum[pcrb_pkg::DUR_W]) begin
            r.saturated = 1'b1;
            ring_dur[prev_idx] = '1;
          end else begin
            ring_dur[prev_idx] = sum[pcrb_pkg::DUR_W-1:0];
          end
        end else begin
          do_append = 1'b1;
        end
      end
      pcrb_pkg::FUNC_READ: begin
        r.level = ring_level[addr];
        r.dur = ring_dur[addr];
      end
      pcrb_pkg::FUNC_ROTATE: ring_head = addr;
      pcrb_pkg::FUNC_CLEAR: begin
        for (int i = 0; i < pcrb_pkg::DEPTH; i++) begin
          ring_level[i] = 1'b0;
          ring_dur[i] = '0;
        end
        ring_head = '0;
      end
      default: ;
    endcase
    // plain append, also the fallback of a merge that cannot extend
    if (do_append) begin
      ring_level[ring_head] = lv;
      ring_dur[ring_head] = d;
      ring_head = ring_head + 1'b1;
    end
    return r;
  endfunction

  // scoreboard: predict on input handshake, compare on output handshake
  always @(posedge clk) begin
    pulse_result_t pred;
    pulse_result_t exp_r;
    pulse_result_t got;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        pred = predict_ring_result(in_func, in_pulse_level, in_pulse_duration, in_position);
        pending_results.push_back(cur_typed ? cur_want : pred);
      end
      if (out_valid && !out_stall) begin
        got = {out_read_level, out_read_duration, out_merged, out_saturated};
        if (pending_results.size() == 0) begin
          fail_count++;
          if (fail_count <= REPORT_LIMIT)
            $display("unexpected item: level %0d dur %h merged %0d sat %0d",
                     got.level, got.dur, got.merged, got.saturated);
        end else begin
          exp_r = pending_results.pop_front();
          if (got !== exp_r) begin
            fail_count++;
            if (fail_count <= REPORT_LIMIT)
              $display("mismatch: exp level %0d dur %h merged %0d sat %0d,",
                       exp_r.level, exp_r.dur, exp_r.merged, exp_r.saturated,
                       " got level %0d dur %h merged %0d sat %0d",
                       got.level, got.dur, got.merged, got.saturated);
          end
        end
      end
    end
  end

  // one directed row
  task automatic add_row(input logic [pcrb_pkg::FUNC_W-1:0] f, input logic lv,
                         input logic [pcrb_pkg::DUR_W-1:0] d,
                         input logic [pcrb_pkg::POS_W-1:0] p,
                         input logic typed, input logic w_level,
                         input logic [pcrb_pkg::DUR_W-1:0] w_dur, input logic w_merged,
                         input logic w_sat);
    stim_row_t row;
    row.func = f;
    row.level = lv;
    row.dur = d;
    row.pos = p;
    row.typed = typed;
    row.want = {w_level, w_dur, w_merged, w_sat};
    directed_rows.push_back(row);
  endtask

  // present one item from a falling edge and hold it until taken
  task automatic send_item(input logic [pcrb_pkg::FUNC_W-1:0] f, input logic lv,
                           input logic [pcrb_pkg::DUR_W-1:0] d,
                           input logic [pcrb_pkg::POS_W-1:0] p,
                           input logic typed, input pulse_result_t want);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_func <= f;
    in_pulse_level <= lv;
    in_pulse_duration <= d;
    in_position <= p;
    cur_typed <= typed;
    cur_want <= want;
    do @(posedge clk); while (!(in_valid && !in_stall));
    @(negedge clk);
  endtask

  task automatic wait_for_drain();
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  // stimulus
  initial begin
    stim_row_t                   row;
    int                          counted;
    int                          clears_left;
    int                          pick;
    logic                        last_level;
    logic [pcrb_pkg::FUNC_W-1:0] f;
    logic                        lv;
    logic [pcrb_pkg::DUR_W-1:0]  d;
    logic [pcrb_pkg::POS_W-1:0]  p;

    rst_n = 1'b0;
    in_valid = 1'b0;
    in_func = pcrb_pkg::FUNC_APPEND;
    in_pulse_level = 1'b0;
    in_pulse_duration = '0;
    in_position = '0;
    cur_typed = 1'b0;
    cur_want = '0;
    idle_pct = 29;
    stall_pct = 29;
    fail_count = 0;
    void'(predict_ring_result(pcrb_pkg::FUNC_CLEAR, 1'b0, '0, '0));

    // empty store after reset
    add_row(pcrb_pkg::FUNC_READ,   1'b0, 32'h0000_0000, 32'h0000_0000,
            1'b1, 1'b0, 32'h0, 1'b0, 1'b0);
    add_row(pcrb_pkg::FUNC_READ,   1'b0, 32'h0000_0000, 32'hFFFF_FFFF,
            1'b1, 1'b0, 32'h0, 1'b0, 1'b0);
    // maximum duration, then a merge that clips
    add_row(pcrb_pkg::FUNC_APPEND, 1'b1, 32'hFFFF_FFFF, 32'h0000_0000,
            1'b1, 1'b0, 32'h0, 1'b0, 1'b0);
    add_row(pcrb_pkg::FUNC_MERGE,  1'b1, 32'h0000_0001, 32'h0000_0000,
            1'b1, 1'b0, 32'h0, 1'b1, 1'b1);
    // largest position wraps back onto the first entry
    add_row(pcrb_pkg::FUNC_READ,   1'b0, 32'h0000_0000, 32'hFFFF_FFFF,
            1'b0, 1'b0, 32'h0, 1'b0, 1'b0);
    // zero-duration append, and a merge that finds an empty previous entry
    add_row(pcrb_pkg::FUNC_APPEND, 1'b0, 32'h0000_0000, 32'h0000_0000,
            1'b1, 1'b0, 32'h0, 1'b0, 1'b0);
    add_row(pcrb_pkg::FUNC_MERGE,  1'b0, 32'h0000_0005, 32'h0000_0000,
            1'b0, 1'b0, 32'h0, 1'b0, 1'b0);
    add_row(pcrb_pkg::FUNC_MERGE,  1'b0, 32'h0000_0007, 32'h0000_0000,
            1'b0, 1'b0, 32'h0, 1'b0, 1'b0);
    add_row(pcrb_pkg::FUNC_MERGE,  1'b1, 32'h0000_0003, 32'h0000_0000,
            1'b0, 1'b0, 32'h0, 1'b0, 1'b0);
    // sum of exactly two to the 32nd, then maximum plus maximum
    add_row(pcrb_pkg::FUNC_APPEND, 1'b0, 32'h8000_0000, 32'h0000_0000,
            1'b1, 1'b0, 32'h0, 1'b0, 1'b0);
    add_row(pcrb_pkg::FUNC_MERGE,  1'b0, 32'h8000_0000, 32'h0000_0000,
            1'b1, 1'b0, 32'h0, 1'b1, 1'b1);
    add_row(pcrb_pkg::FUNC_MERGE,  1'b0, 32'hFFFF_FFFF, 32'h0000_0000,
            1'b1, 1'b0, 32'h0, 1'b1, 1'b1);
    // rotate by the largest offset, then by a whole lap
    add_row(pcrb_pkg::FUNC_ROTATE, 1'b0, 32'h0000_0000, 32'hFFFF_FFFF,
            1'b1, 1'b0, 32'h0, 1'b0, 1'b0);
    add_row(pcrb_pkg::FUNC_READ,   1'b0, 32'h0000_0000, 32'h0000_0001,
            1'b0, 1'b0, 32'h0, 1'b0, 1'b0);
    add_row(pcrb_pkg::FUNC_ROTATE, 1'b0, 32'h0000_0000, 32'h0000_0800,
            1'b1, 1'b0, 32'h0, 1'b0, 1'b0);
    add_row(pcrb_pkg::FUNC_READ,   1'b0, 32'h0000_0000, 32'h0000_07FF,
            1'b0, 1'b0, 32'h0, 1'b0, 1'b0);
    // unused func codes leave everything alone
    add_row(FUNC_RSVD_A,           1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
            1'b1, 1'b0, 32'h0, 1'b0, 1'b0);
    add_row(FUNC_RSVD_B,           1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
            1'b1, 1'b0, 32'h0, 1'b0, 1'b0);
    add_row(FUNC_RSVD_C,           1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
            1'b1, 1'b0, 32'h0, 1'b0, 1'b0);
    add_row(pcrb_pkg::FUNC_MERGE,  1'b1, 32'hFFFF_FFFE, 32'h0000_0000,
            1'b0, 1'b0, 32'h0, 1'b0, 1'b0);
    // clear, then the store reads back empty
    add_row(pcrb_pkg::FUNC_CLEAR,  1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
            1'b1, 1'b0, 32'h0, 1'b0, 1'b0);
    add_row(pcrb_pkg::FUNC_READ,   1'b0, 32'h0000_0000, 32'h0000_0000,
            1'b1, 1'b0, 32'h0, 1'b0, 1'b0);
    add_row(pcrb_pkg::FUNC_READ,   1'b0, 32'h0000_0000, 32'h0000_07FF,
            1'b1, 1'b0, 32'h0, 1'b0, 1'b0);
    add_row(pcrb_pkg::FUNC_MERGE,  1'b0, 32'h0000_0009, 32'h0000_0000,
            1'b1, 1'b0, 32'h0, 1'b0, 1'b0);
    add_row(pcrb_pkg::FUNC_READ,   1'b0, 32'h0000_0000, 32'hFFFF_FFFF,
            1'b0, 1'b0, 32'h0, 1'b0, 1'b0);

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed part
    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      send_item(row.func, row.level, row.dur, row.pos, row.typed, row.want);
    end
    in_valid <= 1'b0;
    @(negedge clk);
    wait_for_drain();

    // random part: mostly pulse trains with reads near the head
    counted = 0;
    clears_left = MAX_CLEARS;
    last_level = 1'b0;
    while (counted < RANDOM_ITEMS) begin
      if (counted == 300) begin
        idle_pct = 0;
        stall_pct = 0;
      end else if (counted == 450) begin
        idle_pct = 29;
        stall_pct = 29;
      end
      if (counted == RANDOM_ITEMS / 2) begin
        in_valid <= 1'b0;
        @(negedge clk);
        wait_for_drain();
      end
      pick = $urandom_range(99);
      lv = 1'($urandom_range(1));
      d = $urandom;
      p = $urandom;
      counted++;
      if (pick < 35) begin
        // run of pulses: mostly same level, small nonzero durations
        f = pcrb_pkg::FUNC_MERGE;
        lv = ($urandom_range(99) < 70) ? last_level : ~last_level;
        case ($urandom_range(19))
          0: d = '0;
          1, 2: d = $urandom;
          default: d = $urandom_range(1000, 1);
        endcase
      end else if (pick < 55) begin
        f = pcrb_pkg::FUNC_APPEND;
        if ($urandom_range(1)) d = $urandom_range(1000);
      end else if (pick < 80) begin
        f = pcrb_pkg::FUNC_READ;
        if ($urandom_range(99) < 60)
          p = ($urandom & 32'hFFFF_F800) | 32'(pcrb_pkg::DEPTH - $urandom_range(16, 1));
      end else if (pick < 88) begin
        f = pcrb_pkg::FUNC_ROTATE;
        case ($urandom_range(2))
          0: p = $urandom_range(4);
          1: p = ($urandom & 32'hFFFF_F800) | 32'(pcrb_pkg::DEPTH - $urandom_range(4, 1));
          default: ;
        endcase
      end else if (pick < 91) begin
        // ignored codes do not count as items
        f = pcrb_pkg::FUNC_W'($urandom_range(FUNC_RSVD_C, FUNC_RSVD_A));
        counted--;
      end else if (pick < 93 && clears_left > 0) begin
        f = pcrb_pkg::FUNC_CLEAR;
        clears_left--;
      end else begin
        // large durations on the same level drive the merge into clipping
        f = pcrb_pkg::FUNC_MERGE;
        lv = last_level;
        d = $urandom | 32'h8000_0000;
      end
      if (f == pcrb_pkg::FUNC_MERGE || f == pcrb_pkg::FUNC_APPEND) last_level = lv;
      send_item(f, lv, d, p, 1'b0, '0);
    end
    in_valid <= 1'b0;
    @(negedge clk);

    // drain and settle
    wait_for_drain();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/pcrb_pkg.sv
rtl/pcrb_front.sv
rtl/pcrb_fifo.sv
rtl/pcrb_back.sv
rtl/pulse_capture_ring_buffer.sv
dv/pulse_capture_ring_buffer_test.sv
